@@ hw/rtl/i2cm_pkg.sv @@
// shared types and constants for the i2c bit-level master
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package i2cm_pkg;

    // opcode values on the input transaction
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_SEND  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_WAIT  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_LONG_DELAY  = 2'd0;
    localparam logic [1:0] CFG_BIT_DELAY   = 2'd1;
    localparam logic [1:0] CFG_SHORT_DELAY = 2'd2;
    localparam logic [1:0] CFG_POLL_LIMIT  = 2'd3;

    // configuration reset values
    localparam logic [15:0] RST_LONG_DELAY  = 16'd400;
    localparam logic [15:0] RST_BIT_DELAY   = 16'd200;
    localparam logic [15:0] RST_SHORT_DELAY = 16'd100;
    localparam logic [7:0]  RST_POLL_LIMIT  = 8'd250;

    // bits per byte on the bus
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // input transaction
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_in;

    // result transaction
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } t_out;

    // configuration register file
    typedef struct packed {
        logic [15:0] long_delay;
        logic [15:0] bit_delay;
        logic [15:0] short_delay;
        logic [7:0]  poll_limit;
    } t_cfg;

    // decoded command class
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_SEND,
        CMD_READ,
        CMD_WAIT
    } t_cmd;

    // classified tick handed from front to back
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_item;

    // bus engine phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST1,
        PH_ST2,
        PH_SP1,
        PH_SP2,
        PH_TX_LOW,
        PH_TX_HIGH,
        PH_TX_TAIL,
        PH_RX_LOW,
        PH_RX_HIGH,
        PH_AK_LOW,
        PH_AK_HIGH,
        PH_WA1,
        PH_WA2,
        PH_WA_POLL
    } t_phase;

endpackage

@@ hw/rtl/i2c_bit_level_master.sv @@
// top level of the i2c bit-level master: config registers, front queue, phase engine
// depends on i2cm_pkg, i2cm_front, i2cm_back
//
// usage:
//   each input transaction is one tick of the bus timing engine and carries an
//   optional command (start, stop, send byte, read byte, wait ack) plus the
//   sampled sda level. every input transaction yields exactly one result
//   transaction with the pin levels, sda drive enable, busy, done, the last
//   received byte and the ack failure flag.
//   input and output channels use valid/stall; a transaction moves when valid
//   is high and stall is low. the config port is a valid/ready write channel
//   that is always ready; write it only while the engine is idle.
//   each accepted tick waits in the two-entry queue, and its result is then
//   held in the output register.
//   throughput: one tick per cycle unless the receiver stalls; the back end
//   steps once per tick, and the queue takes a new tick while a result waits.
//   when the receiver stalls, the output register holds, the queue fills and
//   o_stall rises once both queue entries are taken.
//   reset: synchronous, active low; lines released high with drive on,
//   engine idle, config registers back to their defaults.
`timescale 1ns / 1ps

module i2c_bit_level_master
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_q_pop;

    // config register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_delay  <= RST_LONG_DELAY;
            r_cfg.bit_delay   <= RST_BIT_DELAY;
            r_cfg.short_delay <= RST_SHORT_DELAY;
            r_cfg.poll_limit  <= RST_POLL_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LONG_DELAY:  r_cfg.long_delay  <= i_cfg_data;
                CFG_BIT_DELAY:   r_cfg.bit_delay   <= i_cfg_data;
                CFG_SHORT_DELAY: r_cfg.short_delay <= i_cfg_data;
                CFG_POLL_LIMIT:  r_cfg.poll_limit  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // front: classify and queue
    i2cm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    // back: phase engine and output register
    i2cm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

    // a finishing tick never reports busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.done_res |-> !o_data.busy_res)
        else $error("done and busy reported together");

    // the queue only blocks input while it holds work for the back end
    a_stall_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_q_valid)
        else $error("input stalled with empty queue");

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

@@ hw/rtl/i2cm_front.sv @@
// front end: accepts ticks, classifies the opcode and queues them
// depends on i2cm_pkg
`timescale 1ns / 1ps

module i2cm_front
    import i2cm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_in   i_data,
    output logic  o_q_valid,
    output t_item o_q_item,
    input  logic  i_q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_item            w_item;
    logic             w_push;
    logic             w_pop;

    // opcode classification, unknown codes act as no command
    always_comb begin
        w_item.tx_byte  = i_data.tx_byte;
        w_item.send_ack = i_data.send_ack;
        w_item.sda_in   = i_data.sda_in;
        unique case (i_data.opcode)
            OP_START: w_item.cmd = CMD_START;
            OP_STOP:  w_item.cmd = CMD_STOP;
            OP_SEND:  w_item.cmd = CMD_SEND;
            OP_READ:  w_item.cmd = CMD_READ;
            OP_WAIT:  w_item.cmd = CMD_WAIT;
            default:  w_item.cmd = CMD_NONE;
        endcase
    end

    // queue handshake
    assign o_stall   = (r_count == FULL_CNT);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

@@ hw/rtl/i2cm_back.sv @@
// back end: bus phase engine stepped once per queued tick, with output register
// depends on i2cm_pkg
`timescale 1ns / 1ps

module i2cm_back
    import i2cm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_q_valid,
    input  t_item i_q_item,
    output logic  o_q_pop,
    output logic  o_valid,
    input  logic  i_stall,
    output t_out  o_data
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_delay, n_delay;
    logic [3:0]  r_bit_idx, n_bit_idx;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_poll, n_poll;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_drive, n_drive;
    logic        r_ack_flag, n_ack_flag;
    logic        r_ack_choice, n_ack_choice;
    logic [7:0]  r_rx_hold, n_rx_hold;
    logic        r_out_valid;
    t_out        r_out;
    t_out        w_res;

    logic        w_take;
    logic        w_idle;
    logic [15:0] w_dec;
    logic        w_exp;
    logic        w_poll_evt;
    logic [7:0]  w_poll_cnt;
    logic        w_poll_low;
    logic        w_poll_fail;
    logic [3:0]  w_bit_next;
    logic        w_last_bit;
    logic        w_step_evt;
    logic        w_sda;

    // zero delay acts as one
    function automatic logic [15:0] f_delay(input logic [15:0] d);
        f_delay = (d == '0) ? 16'd1 : d;
    endfunction

    // step one tick when the output register is free or being drained
    assign w_take  = i_q_valid && (!r_out_valid || !i_stall);
    assign o_q_pop = w_take;
    assign w_sda   = i_q_item.sda_in;

    // shared phase conditions
    assign w_idle      = (r_phase == PH_IDLE);
    assign w_dec       = r_delay - {15'd0, (r_delay != '0)};
    assign w_exp       = !w_idle && (r_phase != PH_WA_POLL) && (w_dec == '0);
    assign w_poll_evt  = (r_phase == PH_WA_POLL) || (w_exp && (r_phase == PH_WA2));
    assign w_poll_cnt  = (r_phase == PH_WA2) ? '0 : r_poll;
    assign w_poll_low  = !w_sda;
    assign w_poll_fail = w_sda && (w_poll_cnt >= i_cfg.poll_limit);
    assign w_bit_next  = r_bit_idx + 1'b1;
    assign w_last_bit  = (w_bit_next >= BITS_PER_BYTE);
    assign w_step_evt  = w_idle || w_exp || (r_phase == PH_WA_POLL);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_idle) begin
            unique case (i_q_item.cmd)
                CMD_START: n_phase = PH_ST1;
                CMD_STOP:  n_phase = PH_SP1;
                CMD_SEND:  n_phase = PH_TX_LOW;
                CMD_READ:  n_phase = PH_RX_LOW;
                CMD_WAIT:  n_phase = PH_WA1;
                default:   n_phase = PH_IDLE;
            endcase
        end else if (w_poll_evt) begin
            priority if (w_poll_low) begin
                n_phase = PH_IDLE;
            end else if (w_poll_fail) begin
                n_phase = PH_SP1;
            end else begin
                n_phase = PH_WA_POLL;
            end
        end else if (w_exp) begin
            unique case (r_phase)
                PH_ST1:     n_phase = PH_ST2;
                PH_SP1:     n_phase = PH_SP2;
                PH_TX_LOW:  n_phase = PH_TX_HIGH;
                PH_TX_HIGH: n_phase = PH_TX_TAIL;
                PH_TX_TAIL: n_phase = w_last_bit ? PH_IDLE : PH_TX_LOW;
                PH_RX_LOW:  n_phase = PH_RX_HIGH;
                PH_RX_HIGH: n_phase = w_last_bit ? PH_AK_LOW : PH_RX_LOW;
                PH_AK_LOW:  n_phase = PH_AK_HIGH;
                PH_WA1:     n_phase = PH_WA2;
                default:    n_phase = PH_IDLE;
            endcase
        end
    end

    // delay reload on every phase entry, countdown otherwise
    always_comb begin
        if (w_step_evt) begin
            unique case (n_phase)
                PH_ST1, PH_ST2, PH_SP1, PH_SP2:
                    n_delay = f_delay(i_cfg.long_delay);
                PH_TX_LOW, PH_TX_HIGH, PH_TX_TAIL, PH_RX_LOW, PH_AK_LOW, PH_AK_HIGH:
                    n_delay = f_delay(i_cfg.bit_delay);
                PH_RX_HIGH, PH_WA1, PH_WA2:
                    n_delay = f_delay(i_cfg.short_delay);
                default:
                    n_delay = '0;
            endcase
        end else begin
            n_delay = w_dec;
        end
    end

    // pin levels, shifter, counters and flags
    always_comb begin
        n_bit_idx    = r_bit_idx;
        n_shift      = r_shift;
        n_poll       = r_poll;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_drive      = r_drive;
        n_ack_flag   = r_ack_flag;
        n_ack_choice = r_ack_choice;
        n_rx_hold    = r_rx_hold;
        if (w_idle) begin
            unique case (i_q_item.cmd)
                CMD_START: begin
                    n_drive = 1'b1;
                    n_sda   = 1'b1;
                    n_scl   = 1'b1;
                end
                CMD_STOP: begin
                    n_drive = 1'b1;
                    n_scl   = 1'b0;
                    n_sda   = 1'b0;
                end
                CMD_SEND: begin
                    n_drive   = 1'b1;
                    n_bit_idx = '0;
                    n_sda     = i_q_item.tx_byte[7];
                    n_shift   = {i_q_item.tx_byte[6:0], 1'b0};
                    n_scl     = 1'b0;
                end
                CMD_READ: begin
                    n_drive      = 1'b0;
                    n_scl        = 1'b0;
                    n_shift      = '0;
                    n_bit_idx    = '0;
                    n_ack_choice = i_q_item.send_ack;
                end
                CMD_WAIT: begin
                    n_drive    = 1'b0;
                    n_sda      = 1'b1;
                    n_ack_flag = 1'b0;
                end
                default: begin
                end
            endcase
        end else if (w_poll_evt) begin
            n_poll = w_poll_cnt;
            priority if (w_poll_low) begin
                n_scl = 1'b0;
            end else if (w_poll_fail) begin
                n_ack_flag = 1'b1;
                n_drive    = 1'b1;
                n_scl      = 1'b0;
                n_sda      = 1'b0;
            end else begin
                n_poll = w_poll_cnt + 1'b1;
            end
        end else if (w_exp) begin
            unique case (r_phase)
                PH_ST1:     n_sda = 1'b0;
                PH_ST2:     n_scl = 1'b0;
                PH_SP1:     n_scl = 1'b1;
                PH_SP2:     n_sda = 1'b1;
                PH_TX_LOW:  n_scl = 1'b1;
                PH_TX_HIGH: n_scl = 1'b0;
                PH_TX_TAIL: begin
                    n_bit_idx = w_bit_next;
                    if (!w_last_bit) begin
                        n_sda   = r_shift[7];
                        n_shift = {r_shift[6:0], 1'b0};
                        n_scl   = 1'b0;
                    end
                end
                PH_RX_LOW: begin
                    n_scl   = 1'b1;
                    n_shift = {r_shift[6:0], w_sda};
                end
                PH_RX_HIGH: begin
                    n_bit_idx = w_bit_next;
                    n_scl     = 1'b0;
                    if (w_last_bit) begin
                        n_rx_hold = r_shift;
                        n_drive   = 1'b1;
                        n_sda     = !r_ack_choice;
                    end
                end
                PH_AK_LOW:  n_scl = 1'b1;
                PH_AK_HIGH: n_scl = 1'b0;
                PH_WA1:     n_scl = 1'b1;
                default: begin
                end
            endcase
        end
    end

    // result of this tick
    always_comb begin
        w_res.scl_level  = n_scl;
        w_res.sda_level  = n_sda;
        w_res.sda_drive  = n_drive;
        w_res.busy_res   = (n_phase != PH_IDLE);
        w_res.done_res   = !w_idle && (n_phase == PH_IDLE);
        w_res.rx_byte    = n_rx_hold;
        w_res.ack_failed = n_ack_flag;
    end

    // engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_delay      <= '0;
            r_bit_idx    <= '0;
            r_shift      <= '0;
            r_poll       <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_drive      <= 1'b1;
            r_ack_flag   <= 1'b0;
            r_ack_choice <= 1'b0;
            r_rx_hold    <= '0;
        end else if (w_take) begin
            r_phase      <= n_phase;
            r_delay      <= n_delay;
            r_bit_idx    <= n_bit_idx;
            r_shift      <= n_shift;
            r_poll       <= n_poll;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_drive      <= n_drive;
            r_ack_flag   <= n_ack_flag;
            r_ack_choice <= n_ack_choice;
            r_rx_hold    <= n_rx_hold;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
